// ===== design/sesm_pkg.sv =====
// shared constants, register indexes and controller/datapath link types for the speed meter
package sesm_pkg;

	localparam int NumChannels = 3;
	localparam int CountBits   = 16;
	localparam int InCountW    = 16;
	localparam int ChanW       = 2;
	localparam int ClockW      = 26;
	localparam int PrescaleW   = 10;
	localparam int PeriodW     = 17;
	localparam int SpeedW      = 26;
	localparam int NumW        = 32;
	localparam int StepW       = $clog2(NumW);
	localparam int DivShift    = 6;
	localparam int SpeedMult   = 50;
	localparam int SpeedMaxInt = 33554431;

	localparam logic [ClockW-1:0]    ClockReset    = ClockW'(8000000);
	localparam logic [PrescaleW-1:0] PrescaleReset = PrescaleW'(10);
	localparam logic [SpeedW-1:0]    SpeedMax      = SpeedW'(SpeedMaxInt);
	localparam logic [SpeedW-1:0]    SpeedMin      = {1'b1, {(SpeedW-1){1'b0}}};

	// register indexes
	localparam logic CfgClock    = 1'b0;
	localparam logic CfgPrescale = 1'b1;

	typedef struct packed {
		logic load;
		logic mul;
		logic step;
		logic publish;
	} sesm_cmd_t;

	typedef struct packed {
		logic ch_ok;
		logic out_free;
	} sesm_status_t;

endpackage

// ===== design/sesm_ctrl.sv =====
// controller state machine sequencing load, multiply, divide and output
module sesm_ctrl (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	output logic                  in_stall,
	input  sesm_pkg::sesm_status_t status,
	output sesm_pkg::sesm_cmd_t    cmd
);
	import sesm_pkg::*;

	typedef enum logic [1:0] {
		S_IDLE,
		S_MUL,
		S_DIV,
		S_OUT
	} state_t;

	state_t           state_q;
	logic [StepW-1:0] step_q;

	assign in_stall    = (state_q != S_IDLE);
	assign cmd.load    = in_valid & ~in_stall & status.ch_ok;
	assign cmd.mul     = (state_q == S_MUL);
	assign cmd.step    = (state_q == S_DIV);
	assign cmd.publish = (state_q == S_OUT) & status.out_free;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			step_q  <= '0;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (cmd.load) begin
						state_q <= S_MUL;
					end
				end
				S_MUL: begin
					step_q  <= '0;
					state_q <= S_DIV;
				end
				S_DIV: begin
					step_q <= step_q + StepW'(1);
					if (step_q == StepW'(NumW - 1)) begin
						state_q <= S_OUT;
					end
				end
				S_OUT: begin
					if (status.out_free) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

endmodule

// ===== design/sesm_dp.sv =====
// datapath: config registers, per-channel counts, multiplier, restoring divider, output word
module sesm_dp #(
	parameter int CHANNELS   = sesm_pkg::NumChannels,
	parameter int COUNT_BITS = sesm_pkg::CountBits
) (
	input  logic                                   clk,
	input  logic                                   arst_n,
	input  sesm_pkg::sesm_cmd_t                    cmd,
	output sesm_pkg::sesm_status_t                 status,
	input  logic                                   cfg_we,
	input  logic                                   cfg_index,
	input  logic [sesm_pkg::ClockW-1:0]            cfg_data,
	input  logic                                   action,
	input  logic [sesm_pkg::ChanW-1:0]             channel,
	input  logic [sesm_pkg::InCountW-1:0]          captured_count,
	input  logic                                   direction_level,
	input  logic                                   out_stall,
	output logic                                   out_valid,
	output logic [sesm_pkg::ChanW-1:0]             out_channel,
	output logic signed [sesm_pkg::PeriodW-1:0]    signed_period,
	output logic signed [sesm_pkg::SpeedW-1:0]     speed,
	output logic                                   zero_flag
);
	import sesm_pkg::*;

	localparam int SW  = (COUNT_BITS < InCountW) ? COUNT_BITS : InCountW;
	localparam int CW  = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
	localparam int CEW = CW + ChanW;
	localparam int PW  = SW + PrescaleW;
	localparam int DW  = PW + DivShift;

	logic [ClockW-1:0]    clock_q;
	logic [PrescaleW-1:0] prescale_q;
	logic [SW-1:0]        last_count_q [CHANNELS];

	logic [CEW-1:0] ch_ext;
	logic [CW-1:0]  idx;

	logic [ChanW-1:0] ch_q;
	logic             neg_q;
	logic             zero_q;
	logic [SW-1:0]    pmag_q;
	logic [DW-1:0]    den_q;
	logic [DW-1:0]    rem_q;
	logic [NumW-1:0]  quo_q;

	logic [PW-1:0]   prod;
	logic [DW:0]     shifted;
	logic [DW:0]     trial;
	logic            pos_sat;
	logic            neg_sat;
	logic [SpeedW-1:0]  speed_val;
	logic [PeriodW-1:0] period_val;

	logic               out_valid_q;
	logic [ChanW-1:0]   out_ch_q;
	logic [PeriodW-1:0] period_q;
	logic [SpeedW-1:0]  speed_q;
	logic               zero_flag_q;

	assign ch_ext          = {{CW{1'b0}}, channel};
	assign idx             = ch_ext[CW-1:0];
	assign status.ch_ok    = (ch_ext < CEW'(CHANNELS));
	assign status.out_free = ~out_valid_q | ~out_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clock_q    <= ClockReset;
			prescale_q <= PrescaleReset;
		end else if (cfg_we) begin
			case (cfg_index)
				CfgClock:    clock_q    <= cfg_data;
				CfgPrescale: prescale_q <= cfg_data[PrescaleW-1:0];
				default:     clock_q    <= clock_q;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < CHANNELS; i++) begin
				last_count_q[i] <= '0;
			end
		end else if (cmd.load) begin
			last_count_q[idx] <= action ? '0 : captured_count[SW-1:0];
		end
	end

	assign prod    = PW'(pmag_q) * PW'(prescale_q);
	assign shifted = {rem_q, quo_q[NumW-1]};
	assign trial   = shifted - {1'b0, den_q};

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			ch_q   <= channel;
			neg_q  <= ~direction_level;
			pmag_q <= action ? '0 : last_count_q[idx];
		end
		if (cmd.mul) begin
			den_q  <= {prod, {DivShift{1'b0}}};
			quo_q  <= NumW'(clock_q) * NumW'(SpeedMult);
			rem_q  <= '0;
			zero_q <= (pmag_q == '0) | (prescale_q == '0);
		end
		if (cmd.step) begin
			if (!trial[DW]) begin
				rem_q <= trial[DW-1:0];
				quo_q <= {quo_q[NumW-2:0], 1'b1};
			end else begin
				rem_q <= shifted[DW-1:0];
				quo_q <= {quo_q[NumW-2:0], 1'b0};
			end
		end
	end

	// saturate the magnitude to the signed output range
	assign pos_sat    = quo_q > NumW'(SpeedMaxInt);
	assign neg_sat    = quo_q > NumW'(SpeedMaxInt + 1);
	assign period_val = neg_q ? (PeriodW'(0) - PeriodW'(pmag_q)) : PeriodW'(pmag_q);

	always_comb begin
		if (zero_q) begin
			speed_val = '0;
		end else if (neg_q) begin
			speed_val = neg_sat ? SpeedMin : (SpeedW'(0) - quo_q[SpeedW-1:0]);
		end else begin
			speed_val = pos_sat ? SpeedMax : quo_q[SpeedW-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.publish) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.publish) begin
			out_ch_q    <= ch_q;
			period_q    <= period_val;
			speed_q     <= speed_val;
			zero_flag_q <= zero_q;
		end
	end

	assign out_valid     = out_valid_q;
	assign out_channel   = out_ch_q;
	assign signed_period = period_q;
	assign speed         = speed_q;
	assign zero_flag     = zero_flag_q;

endmodule

// ===== design/signed_encoder_speed_meter.sv =====
// Encoder speed meter with direction for several channels. Each capture word reports the
// count stored by the channel's previous capture as a signed period and a speed of
// timer_clock_hz*50 / (period*prescale*64), truncated toward zero; an overflow word
// clears the channel and reports zero with zero_flag set. One word is processed at a
// time: a word with a valid channel is latched, multiplied, put through 32 steps of the
// one-bit-per-cycle restoring divider and handed to the output register; in_stall is
// high after it is taken until that hand-off, which waits while the output register is
// still full. A word for a channel beyond the configured count is dropped and gives no
// result. Configuration writes take effect at once and are meant for an idle block.
module signed_encoder_speed_meter #(
	parameter int CHANNELS   = sesm_pkg::NumChannels,
	parameter int COUNT_BITS = sesm_pkg::CountBits
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                cfg_we,
	input  logic                                cfg_index,
	input  logic [sesm_pkg::ClockW-1:0]         cfg_data,
	input  logic                                in_valid,
	output logic                                in_stall,
	input  logic                                action,
	input  logic [sesm_pkg::ChanW-1:0]          channel,
	input  logic [sesm_pkg::InCountW-1:0]       captured_count,
	input  logic                                direction_level,
	output logic                                out_valid,
	input  logic                                out_stall,
	output logic [sesm_pkg::ChanW-1:0]          out_channel,
	output logic signed [sesm_pkg::PeriodW-1:0] signed_period,
	output logic signed [sesm_pkg::SpeedW-1:0]  speed,
	output logic                                zero_flag
);
	import sesm_pkg::*;

	sesm_cmd_t    cmd;
	sesm_status_t status;

	sesm_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.status   (status),
		.cmd      (cmd)
	);

	sesm_dp #(
		.CHANNELS   (CHANNELS),
		.COUNT_BITS (COUNT_BITS)
	) u_dp (
		.clk             (clk),
		.arst_n          (arst_n),
		.cmd             (cmd),
		.status          (status),
		.cfg_we          (cfg_we),
		.cfg_index       (cfg_index),
		.cfg_data        (cfg_data),
		.action          (action),
		.channel         (channel),
		.captured_count  (captured_count),
		.direction_level (direction_level),
		.out_stall       (out_stall),
		.out_valid       (out_valid),
		.out_channel     (out_channel),
		.signed_period   (signed_period),
		.speed           (speed),
		.zero_flag       (zero_flag)
	);

endmodule

// ===== tb/tb.sv =====
`timescale 1ns / 1ps
// self-checking testbench for the three-channel signed encoder speed meter

module tb;
	import sesm_pkg::*;

	localparam logic ACT_CAPTURE     = 1'b0;
	localparam logic ACT_OVERFLOW    = 1'b1;
	localparam int   CYCLE_LIMIT     = 400000;
	localparam int   SETTLE_CYCLES   = 50;
	localparam int   LONG_HOLD       = 400;
	localparam int   WORDS_PER_PHASE = 120;
	localparam int   NUM_PHASES      = 8;
	localparam int   NUM_ROWS        = 16;

	typedef enum int {IDLE_NONE, IDLE_SENDER, IDLE_RECEIVER, IDLE_BOTH} idle_mode_t;
	typedef enum logic {ROW_PREDICT, ROW_TYPED} row_kind_t;

	typedef struct packed {
		logic [ChanW-1:0]          ch;
		logic signed [PeriodW-1:0] period;
		logic signed [SpeedW-1:0]  speed;
		logic                      zf;
	} speed_word_t;

	typedef struct packed {
		logic                act;
		logic [ChanW-1:0]    ch;
		logic [InCountW-1:0] cnt;
		logic                dir;
		row_kind_t           kind;
		speed_word_t         typed;
	} stim_row_t;

	logic                        clk             = 1'b0;
	logic                        arst_n          = 1'b0;
	logic                        cfg_we          = 1'b0;
	logic                        cfg_index       = 1'b0;
	logic [ClockW-1:0]           cfg_data        = '0;
	logic                        in_valid        = 1'b0;
	logic                        in_stall;
	logic                        action          = 1'b0;
	logic [ChanW-1:0]            channel         = '0;
	logic [InCountW-1:0]         captured_count  = '0;
	logic                        direction_level = 1'b0;
	logic                        out_valid;
	logic                        out_stall       = 1'b0;
	logic [ChanW-1:0]            out_channel;
	logic signed [PeriodW-1:0]   signed_period;
	logic signed [SpeedW-1:0]    speed;
	logic                        zero_flag;

	logic [CountBits-1:0] tacho_last [NumChannels];
	logic [ClockW-1:0]    clock_hz_cfg;
	logic [PrescaleW-1:0] prescale_cfg;
	speed_word_t          speed_q [$];
	speed_word_t          want;
	stim_row_t            rows [NUM_ROWS];

	int   errors          = 0;
	int   words_sent      = 0;
	int   words_dropped   = 0;
	int   results_seen    = 0;
	int   zero_seen       = 0;
	int   sat_seen        = 0;
	int   cycle_count     = 0;
	int   sender_idle_pct = 0;
	int   recv_stall_pct  = 0;
	int   held            = 0;
	logic hold_req        = 1'b0;

	signed_encoder_speed_meter DUT (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.action(action),
		.channel(channel),
		.captured_count(captured_count),
		.direction_level(direction_level),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.out_channel(out_channel),
		.signed_period(signed_period),
		.speed(speed),
		.zero_flag(zero_flag)
	);

	always #5 clk = ~clk;

	function automatic bit predict_speed(input logic act, input logic [ChanW-1:0] ch,
			input logic [InCountW-1:0] cnt, input logic dir, output speed_word_t res);
		longint per, num, den, quo;
		res = '{ch, '0, '0, 1'b1};
		if (ch >= NumChannels)
			return 1'b0;
		if (act == ACT_OVERFLOW) begin
			tacho_last[ch] = '0;
			return 1'b1;
		end
		per = longint'(tacho_last[ch]);
		if (!dir)
			per = -per;
		tacho_last[ch] = cnt[CountBits-1:0];
		res.period = per[PeriodW-1:0];
		if (per != 0 && prescale_cfg != 0) begin
			num = longint'(clock_hz_cfg);
			num = num * SpeedMult;
			den = longint'(prescale_cfg);
			den = per * den * (1 << DivShift);
			quo = num / den;
			if (quo > SpeedMaxInt)
				quo = SpeedMaxInt;
			if (quo < -SpeedMaxInt - 1)
				quo = -SpeedMaxInt - 1;
			res.speed = quo[SpeedW-1:0];
			res.zf = 1'b0;
		end
		return 1'b1;
	endfunction

	task automatic offer_word(input logic act, input logic [ChanW-1:0] ch,
			input logic [InCountW-1:0] cnt, input logic dir, input bit typed_on,
			input speed_word_t typed_res);
		speed_word_t res;
		bit has_res;
		while ($urandom_range(0, 99) < sender_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		action <= act;
		channel <= ch;
		captured_count <= cnt;
		direction_level <= dir;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		words_sent++;
		has_res = predict_speed(act, ch, cnt, dir, res);
		if (typed_on)
			res = typed_res;
		if (has_res)
			speed_q.push_back(res);
		else
			words_dropped++;
	endtask

	task automatic settle();
		in_valid <= 1'b0;
		while (speed_q.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic configure(input logic [ClockW-1:0] hz, input logic [PrescaleW-1:0] pre);
		cfg_we <= 1'b1;
		cfg_index <= CfgClock;
		cfg_data <= hz;
		@(posedge clk);
		cfg_index <= CfgPrescale;
		cfg_data <= ClockW'(pre);
		@(posedge clk);
		cfg_we <= 1'b0;
		clock_hz_cfg = hz;
		prescale_cfg = pre;
	endtask

	task automatic report(input string name, input int exp_v, input int got_v);
		errors++;
		$display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, exp_v, got_v);
	endtask

	// output side: random stall, one long hold, and the field checks
	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall) begin
			results_seen++;
			if (speed_q.size() == 0) begin
				errors++;
				$display("%0t: unexpected word, actual ch %0d period %0d speed %0d zero %0d",
					$time, out_channel, signed_period, speed, zero_flag);
			end else begin
				want = speed_q.pop_front();
				if (want.ch !== out_channel)
					report("out_channel", int'(want.ch), int'(out_channel));
				if (want.period !== signed_period)
					report("signed_period", int'(want.period), int'(signed_period));
				if (want.speed !== speed)
					report("speed", int'(want.speed), int'(speed));
				if (want.zf !== zero_flag)
					report("zero_flag", int'(want.zf), int'(zero_flag));
				if (zero_flag)
					zero_seen++;
				if (speed == SpeedMax || speed == SpeedMin)
					sat_seen++;
			end
		end
		if (hold_req && held < LONG_HOLD) begin
			out_stall <= 1'b1;
			held++;
		end else begin
			out_stall <= ($urandom_range(0, 99) < recv_stall_pct);
		end
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("%0t: timeout with %0d words outstanding", $time, speed_q.size());
			$display("RESULT: ERROR");
			$finish;
		end
	end

	initial begin : stim
		int p;
		int made;
		int sel;
		idle_mode_t mode;
		logic a;
		logic [ChanW-1:0] c;
		logic [InCountW-1:0] n;
		logic d;
		logic [ClockW-1:0] hz_set [NUM_PHASES];
		logic [PrescaleW-1:0] pre_set [NUM_PHASES];

		clock_hz_cfg = ClockReset;
		prescale_cfg = PrescaleReset;
		foreach (tacho_last[i])
			tacho_last[i] = '0;

		rows[0]  = '{ACT_CAPTURE,  2'd0, 16'hFFFF, 1'b1, ROW_TYPED,   '{2'd0, '0, '0, 1'b1}};
		rows[1]  = '{ACT_CAPTURE,  2'd0, 16'h0001, 1'b1, ROW_PREDICT, '0};
		rows[2]  = '{ACT_CAPTURE,  2'd0, 16'h0000, 1'b0, ROW_PREDICT, '0};
		rows[3]  = '{ACT_CAPTURE,  2'd0, 16'h0005, 1'b1, ROW_TYPED,   '{2'd0, '0, '0, 1'b1}};
		rows[4]  = '{ACT_OVERFLOW, 2'd0, 16'hFFFF, 1'b0, ROW_TYPED,   '{2'd0, '0, '0, 1'b1}};
		rows[5]  = '{ACT_CAPTURE,  2'd0, 16'h0064, 1'b0, ROW_TYPED,   '{2'd0, '0, '0, 1'b1}};
		rows[6]  = '{ACT_CAPTURE,  2'd3, 16'hFFFF, 1'b1, ROW_PREDICT, '0};
		rows[7]  = '{ACT_OVERFLOW, 2'd3, 16'h0000, 1'b0, ROW_PREDICT, '0};
		rows[8]  = '{ACT_CAPTURE,  2'd1, 16'h8000, 1'b1, ROW_TYPED,   '{2'd1, '0, '0, 1'b1}};
		rows[9]  = '{ACT_CAPTURE,  2'd1, 16'h7FFF, 1'b0, ROW_PREDICT, '0};
		rows[10] = '{ACT_CAPTURE,  2'd2, 16'hAAAA, 1'b1, ROW_TYPED,   '{2'd2, '0, '0, 1'b1}};
		rows[11] = '{ACT_CAPTURE,  2'd2, 16'h5555, 1'b1, ROW_PREDICT, '0};
		rows[12] = '{ACT_OVERFLOW, 2'd1, 16'hFFFF, 1'b1, ROW_TYPED,   '{2'd1, '0, '0, 1'b1}};
		rows[13] = '{ACT_CAPTURE,  2'd2, 16'h0001, 1'b0, ROW_PREDICT, '0};
		rows[14] = '{ACT_CAPTURE,  2'd3, 16'h0000, 1'b0, ROW_PREDICT, '0};
		rows[15] = '{ACT_CAPTURE,  2'd2, 16'h0002, 1'b1, ROW_PREDICT, '0};

		hz_set[0] = 26'd8000000;
		pre_set[0] = 10'd10;
		hz_set[1] = 26'd1;
		pre_set[1] = 10'd1;
		hz_set[2] = 26'd40000000;
		pre_set[2] = 10'd512;
		hz_set[3] = 26'h3FFFFFF;
		pre_set[3] = 10'd1;
		hz_set[4] = ClockW'($urandom_range(1, 40000000));
		pre_set[4] = PrescaleW'($urandom_range(1, 512));
		hz_set[5] = 26'd5000000;
		pre_set[5] = 10'd0;
		hz_set[6] = 26'h3FFFFFF;
		pre_set[6] = 10'h3FF;
		hz_set[7] = ClockW'($urandom);
		pre_set[7] = PrescaleW'($urandom);

		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		for (int k = 0; k < NUM_ROWS; k++)
			offer_word(rows[k].act, rows[k].ch, rows[k].cnt, rows[k].dir,
				rows[k].kind == ROW_TYPED, rows[k].typed);
		settle();

		for (p = 0; p < NUM_PHASES; p++) begin
			configure(hz_set[p], pre_set[p]);
			mode = idle_mode_t'(p % 4);
			sender_idle_pct = (mode == IDLE_SENDER) ? 79 : (mode == IDLE_BOTH) ? 31 : 0;
			recv_stall_pct = (mode == IDLE_RECEIVER) ? 79 : (mode == IDLE_BOTH) ? 31 : 0;
			// back-pressure from a long output hold while words keep coming
			if (p == 4)
				hold_req <= 1'b1;
			made = 0;
			while (made < WORDS_PER_PHASE) begin
				c = ($urandom_range(0, 99) < 8) ? 2'd3 : ChanW'($urandom_range(0, 2));
				a = ($urandom_range(0, 99) < 12) ? ACT_OVERFLOW : ACT_CAPTURE;
				d = 1'($urandom_range(0, 1));
				sel = $urandom_range(0, 3);
				case (sel)
					0: n = InCountW'($urandom_range(0, 15));
					1: begin
						case ($urandom_range(0, 3))
							0: n = 16'h0000;
							1: n = 16'h0001;
							2: n = 16'h8000;
							default: n = 16'hFFFF;
						endcase
					end
					default: n = InCountW'($urandom_range(0, 65535));
				endcase
				offer_word(a, c, n, d, 1'b0, '0);
				if (c < NumChannels)
					made++;
			end
			settle();
		end

		$display("run covered %0d words (%0d on an unused channel) across %0d settings",
			words_sent, words_dropped, NUM_PHASES + 1);
		$display("four idling patterns, a %0d-cycle output hold: %0d results, %0d zero, %0d sat",
			LONG_HOLD, results_seen, zero_seen, sat_seen);
		if (errors == 0)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end

endmodule
